FILE: src/pera_pkg.sv
package pera_pkg;

	localparam int POSITION_BITS_DEF = 15;
	localparam int SIZE_W = 15;
	localparam int VALUE_W = 32;
	localparam int CFG_INDEX_W = 1;

	localparam logic [SIZE_W-1:0] SCREEN_WIDTH_RST = 15'd640;
	localparam logic [SIZE_W-1:0] SCREEN_HEIGHT_RST = 15'd480;

	localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

	localparam logic REQ_EVENT = 1'b0;
	localparam logic REQ_TAKE_SCROLL = 1'b1;

	localparam logic [15:0] EV_SYNC = 16'd0;
	localparam logic [15:0] EV_KEY = 16'd1;
	localparam logic [15:0] EV_REL = 16'd2;
	localparam logic [15:0] EV_ABS = 16'd3;

	localparam logic [15:0] CODE_ABS_X = 16'd0;
	localparam logic [15:0] CODE_ABS_Y = 16'd1;
	localparam logic [15:0] CODE_BTN_LEFT = 16'd272;
	localparam logic [15:0] CODE_BTN_RIGHT = 16'd273;
	localparam logic [15:0] CODE_WHEEL = 16'd8;

	localparam logic signed [VALUE_W-1:0] SCROLL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VALUE_W-1:0] SCROLL_MIN = 32'sh8000_0000;

endpackage

FILE: src/pointer_event_report_assembler.sv
// Channel | Direction | Handshake             | Payload
// cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data (screen width, height)
// in      | in        | in_valid / in_ready   | req_type, ev_type, ev_code, ev_value
// out     | out       | out_valid / out_ready | cursor_*, button_*, control_click, scroll_*
//
// One transaction a cycle unless out_ready stalls; each result shows in the cycle after its input is accepted.
// The path sets the rate: one position-by-size multiply feeding the result register.
// Reset: position, masks, buttons and scroll total clear; screen size goes to 640 x 480.
// A stalled output holds its result; in_ready follows out_ready when a result is waiting.
// cfg_ready is always high.
module pointer_event_report_assembler
	import pera_pkg::*;
#(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_INDEX_W-1:0]        cfg_index,
	input  logic [SIZE_W-1:0]             cfg_data,

	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          req_type,
	input  logic [15:0]                   ev_type,
	input  logic [15:0]                   ev_code,
	input  logic signed [VALUE_W-1:0]     ev_value,

	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          cursor_valid,
	output logic [SIZE_W-1:0]             cursor_x,
	output logic [SIZE_W-1:0]             cursor_y,
	output logic                          button_event_valid,
	output logic                          button_down,
	output logic                          control_click,
	output logic [1:0]                    button_state,
	output logic                          scroll_posted,
	output logic signed [VALUE_W-1:0]     scroll_amount
);

	localparam int PROD_W = POSITION_BITS + SIZE_W;
	localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

	logic [SIZE_W-1:0]        screen_width_q;
	logic [SIZE_W-1:0]        screen_height_q;

	logic                     position_known_q;
	logic [POSITION_BITS-1:0] abs_x_q;
	logic [POSITION_BITS-1:0] abs_y_q;
	logic [1:0]               known_mask_q;
	logic [1:0]               pressed_mask_q;
	logic [1:0]               previous_buttons_q;
	logic signed [VALUE_W-1:0] scroll_total_q;

	logic                     out_valid_q;
	logic                     cursor_valid_q;
	logic [SIZE_W-1:0]        cursor_x_q;
	logic [SIZE_W-1:0]        cursor_y_q;
	logic                     button_event_valid_q;
	logic                     button_down_q;
	logic                     control_click_q;
	logic [1:0]               button_state_q;
	logic                     scroll_posted_q;
	logic signed [VALUE_W-1:0] scroll_amount_q;

	logic                     accept;
	logic                     is_event;
	logic                     hit_abs_x;
	logic                     hit_abs_y;
	logic                     hit_left;
	logic                     hit_right;
	logic                     hit_wheel;
	logic                     hit_sync;
	logic [POSITION_BITS-1:0] pos_sat;
	logic [PROD_W-1:0]        prod_x;
	logic [PROD_W-1:0]        prod_y;
	logic [SIZE_W-1:0]        scaled_x;
	logic [SIZE_W-1:0]        scaled_y;
	logic [1:0]               merged;
	logic                     button_change;
	logic signed [VALUE_W:0]  scroll_sum;
	logic signed [VALUE_W-1:0] scroll_next;

	assign cfg_ready = 1'b1;
	assign in_ready = !out_valid_q || out_ready;
	assign accept = in_valid && in_ready;

	assign is_event = (req_type == REQ_EVENT);
	assign hit_abs_x = is_event && ev_type == EV_ABS && ev_code == CODE_ABS_X;
	assign hit_abs_y = is_event && ev_type == EV_ABS && ev_code == CODE_ABS_Y;
	assign hit_left = is_event && ev_type == EV_KEY && ev_code == CODE_BTN_LEFT;
	assign hit_right = is_event && ev_type == EV_KEY && ev_code == CODE_BTN_RIGHT;
	assign hit_wheel = is_event && ev_type == EV_REL && ev_code == CODE_WHEEL;
	assign hit_sync = is_event && ev_type == EV_SYNC;

	always_comb begin
		if (ev_value[VALUE_W-1]) begin
			pos_sat = '0;
		end else if (|ev_value[VALUE_W-2:POSITION_BITS]) begin
			pos_sat = POS_MAX;
		end else begin
			pos_sat = ev_value[POSITION_BITS-1:0];
		end
	end

	assign prod_x = PROD_W'(abs_x_q) * PROD_W'(screen_width_q);
	assign prod_y = PROD_W'(abs_y_q) * PROD_W'(screen_height_q);
	assign scaled_x = prod_x[PROD_W-1:POSITION_BITS] + SIZE_W'(1);
	assign scaled_y = prod_y[PROD_W-1:POSITION_BITS] + SIZE_W'(1);

	assign merged = (pressed_mask_q & known_mask_q) | (previous_buttons_q & ~known_mask_q);
	assign button_change = (previous_buttons_q != 2'b00) != (merged != 2'b00);

	assign scroll_sum = {scroll_total_q[VALUE_W-1], scroll_total_q}
		+ {ev_value[VALUE_W-1], ev_value};

	always_comb begin
		if (scroll_sum[VALUE_W] != scroll_sum[VALUE_W-1]) begin
			scroll_next = scroll_sum[VALUE_W] ? SCROLL_MIN : SCROLL_MAX;
		end else begin
			scroll_next = scroll_sum[VALUE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q <= SCREEN_WIDTH_RST;
			screen_height_q <= SCREEN_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SCREEN_WIDTH: screen_width_q <= cfg_data;
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_known_q <= 1'b0;
			abs_x_q <= '0;
			abs_y_q <= '0;
			known_mask_q <= 2'b00;
			pressed_mask_q <= 2'b00;
			previous_buttons_q <= 2'b00;
			scroll_total_q <= '0;
		end else if (accept) begin
			if (!is_event) begin
				scroll_total_q <= '0;
			end else if (hit_abs_x) begin
				position_known_q <= 1'b1;
				abs_x_q <= pos_sat;
			end else if (hit_abs_y) begin
				position_known_q <= 1'b1;
				abs_y_q <= pos_sat;
			end else if (hit_left) begin
				known_mask_q[0] <= 1'b1;
				if (ev_value != '0) begin
					pressed_mask_q[0] <= 1'b1;
				end
			end else if (hit_right) begin
				known_mask_q[1] <= 1'b1;
				if (ev_value != '0) begin
					pressed_mask_q[1] <= 1'b1;
				end
			end else if (hit_wheel) begin
				scroll_total_q <= scroll_next;
			end else if (hit_sync) begin
				position_known_q <= 1'b0;
				previous_buttons_q <= merged;
				known_mask_q <= 2'b00;
				pressed_mask_q <= 2'b00;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cursor_valid_q <= hit_sync && position_known_q;
			cursor_x_q <= (hit_sync && position_known_q) ? scaled_x : '0;
			cursor_y_q <= (hit_sync && position_known_q) ? scaled_y : '0;
			button_event_valid_q <= hit_sync && button_change;
			button_down_q <= hit_sync && button_change && merged != 2'b00;
			control_click_q <= hit_sync && button_change && merged[1];
			button_state_q <= hit_sync ? merged : previous_buttons_q;
			scroll_posted_q <= hit_wheel;
			scroll_amount_q <= is_event ? '0 : scroll_total_q;
		end
	end

	assign out_valid = out_valid_q;
	assign cursor_valid = cursor_valid_q;
	assign cursor_x = cursor_x_q;
	assign cursor_y = cursor_y_q;
	assign button_event_valid = button_event_valid_q;
	assign button_down = button_down_q;
	assign control_click = control_click_q;
	assign button_state = button_state_q;
	assign scroll_posted = scroll_posted_q;
	assign scroll_amount = scroll_amount_q;

`ifndef SYNTHESIS
	a_cursor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && cursor_valid_q |-> cursor_x_q != '0 && cursor_y_q != '0)
		else $error("scaled cursor position is zero");

	a_click_needs_down: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && control_click_q |-> button_event_valid_q && button_down_q)
		else $error("control click without a button down event");

	a_pressed_within_known: assert property (@(posedge clk) disable iff (!arst_n)
		(pressed_mask_q & ~known_mask_q) == 2'b00)
		else $error("pressed button outside known mask");

	a_take_clears_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req_type == REQ_TAKE_SCROLL |=> scroll_total_q == '0)
		else $error("scroll total not cleared after take");

	a_sync_clears_masks: assert property (@(posedge clk) disable iff (!arst_n)
		accept && hit_sync |=> known_mask_q == 2'b00 && !position_known_q)
		else $error("sync did not clear latched report state");
`endif

endmodule

FILE: tb/tb_pointer_event_report_assembler.sv
module tb_pointer_event_report_assembler
	import pera_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int POS_MAX = (1 << POSITION_BITS_DEF) - 1;

	typedef struct {
		logic                      req;
		logic [15:0]               typ;
		logic [15:0]               code;
		logic signed [VALUE_W-1:0] value;
	} pointer_event_t;

	typedef struct {
		logic                      cursor_valid;
		logic [SIZE_W-1:0]         cursor_x;
		logic [SIZE_W-1:0]         cursor_y;
		logic                      button_event_valid;
		logic                      button_down;
		logic                      control_click;
		logic [1:0]                button_state;
		logic                      scroll_posted;
		logic signed [VALUE_W-1:0] scroll_amount;
	} report_t;

	typedef struct {
		pointer_event_t ev;
		logic           typed;
		report_t        want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_W-1:0]    cfg_index = '0;
	logic [SIZE_W-1:0]         cfg_data = '0;

	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic                      req_type = REQ_EVENT;
	logic [15:0]               ev_type = '0;
	logic [15:0]               ev_code = '0;
	logic signed [VALUE_W-1:0] ev_value = '0;

	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic                      cursor_valid;
	logic [SIZE_W-1:0]         cursor_x;
	logic [SIZE_W-1:0]         cursor_y;
	logic                      button_event_valid;
	logic                      button_down;
	logic                      control_click;
	logic [1:0]                button_state;
	logic                      scroll_posted;
	logic signed [VALUE_W-1:0] scroll_amount;

	pointer_event_report_assembler dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.req_type           (req_type),
		.ev_type            (ev_type),
		.ev_code            (ev_code),
		.ev_value           (ev_value),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.cursor_valid       (cursor_valid),
		.cursor_x           (cursor_x),
		.cursor_y           (cursor_y),
		.button_event_valid (button_event_valid),
		.button_down        (button_down),
		.control_click      (control_click),
		.button_state       (button_state),
		.scroll_posted      (scroll_posted),
		.scroll_amount      (scroll_amount)
	);

	logic [SIZE_W-1:0]         screen_w = SCREEN_WIDTH_RST;
	logic [SIZE_W-1:0]         screen_h = SCREEN_HEIGHT_RST;
	logic                      pos_known = 1'b0;
	logic [SIZE_W-1:0]         latched_x = '0;
	logic [SIZE_W-1:0]         latched_y = '0;
	logic [1:0]                known_buttons = '0;
	logic [1:0]                pressed_buttons = '0;
	logic [1:0]                prev_buttons = '0;
	logic signed [VALUE_W-1:0] scroll_total = '0;

	report_t pending_reports[$];
	report_t quiet = '{default: '0};
	int mismatches = 0;
	int events_sent = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [SIZE_W-1:0] clamp_position(input logic signed [VALUE_W-1:0] v);
		if (v < 0)
			return '0;
		if (v > POS_MAX)
			return SIZE_W'(POS_MAX);
		return v[SIZE_W-1:0];
	endfunction

	function automatic logic [SIZE_W-1:0] scale_to_screen(input logic [SIZE_W-1:0] pos,
			input logic [SIZE_W-1:0] size);
		logic [2*SIZE_W-1:0] prod;
		prod = {{SIZE_W{1'b0}}, pos} * {{SIZE_W{1'b0}}, size};
		prod = prod >> POSITION_BITS_DEF;
		return prod[SIZE_W-1:0] + SIZE_W'(1);
	endfunction

	function automatic report_t assemble_report(input pointer_event_t ev);
		report_t r;
		logic [1:0] merged;
		longint sum;
		r = quiet;
		r.button_state = prev_buttons;
		if (ev.req == REQ_TAKE_SCROLL) begin
			r.scroll_amount = scroll_total;
			scroll_total = '0;
		end else if (ev.typ == EV_ABS && ev.code == CODE_ABS_X) begin
			pos_known = 1'b1;
			latched_x = clamp_position(ev.value);
		end else if (ev.typ == EV_ABS && ev.code == CODE_ABS_Y) begin
			pos_known = 1'b1;
			latched_y = clamp_position(ev.value);
		end else if (ev.typ == EV_KEY && ev.code == CODE_BTN_LEFT) begin
			known_buttons[0] = 1'b1;
			if (ev.value != 0)
				pressed_buttons[0] = 1'b1;
		end else if (ev.typ == EV_KEY && ev.code == CODE_BTN_RIGHT) begin
			known_buttons[1] = 1'b1;
			if (ev.value != 0)
				pressed_buttons[1] = 1'b1;
		end else if (ev.typ == EV_REL && ev.code == CODE_WHEEL) begin
			sum = longint'(scroll_total) + longint'(ev.value);
			if (sum > longint'(SCROLL_MAX))
				sum = longint'(SCROLL_MAX);
			if (sum < longint'(SCROLL_MIN))
				sum = longint'(SCROLL_MIN);
			scroll_total = sum[VALUE_W-1:0];
			r.scroll_posted = 1'b1;
		end else if (ev.typ == EV_SYNC) begin
			if (pos_known) begin
				r.cursor_valid = 1'b1;
				r.cursor_x = scale_to_screen(latched_x, screen_w);
				r.cursor_y = scale_to_screen(latched_y, screen_h);
			end
			pos_known = 1'b0;
			merged = (pressed_buttons & known_buttons) | (prev_buttons & ~known_buttons);
			if ((prev_buttons != 2'd0) != (merged != 2'd0)) begin
				r.button_event_valid = 1'b1;
				r.button_down = (merged != 2'd0);
				r.control_click = merged[1];
			end
			r.button_state = merged;
			prev_buttons = merged;
			known_buttons = '0;
			pressed_buttons = '0;
		end
		return r;
	endfunction

	function automatic row_t plain_row(input logic req, input logic [15:0] typ,
			input logic [15:0] code, input logic signed [VALUE_W-1:0] value);
		row_t r;
		r.ev.req = req;
		r.ev.typ = typ;
		r.ev.code = code;
		r.ev.value = value;
		r.typed = 1'b0;
		r.want = quiet;
		return r;
	endfunction

	function automatic row_t row_with_result(input row_t r, input report_t want);
		r.typed = 1'b1;
		r.want = want;
		return r;
	endfunction

	function automatic logic signed [VALUE_W-1:0] pick_abs_value();
		case ($urandom_range(9))
			0: return $urandom;
			1: return 32'sh8000_0000;
			2: return 32'sh7FFF_FFFF;
			default: return $urandom_range(POS_MAX);
		endcase
	endfunction

	function automatic logic signed [VALUE_W-1:0] pick_key_value();
		case ($urandom_range(3))
			2: return 32'sd1;
			3: return $urandom;
			default: return 32'sd0;
		endcase
	endfunction

	function automatic logic signed [VALUE_W-1:0] pick_wheel_value();
		case ($urandom_range(9))
			0: return $urandom;
			1: return 32'sh7FFF_FFFF;
			2: return 32'sh8000_0000;
			default: return $signed($urandom_range(16)) - 8;
		endcase
	endfunction

	task automatic compare_field(input string name, input logic [VALUE_W-1:0] want,
			input logic [VALUE_W-1:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected %h, got %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_report();
		report_t want;
		if (pending_reports.size() == 0) begin
			$display("%0t ns: result expected none, got cursor %h/%h/%h buttons %h scroll %h",
				$time, cursor_valid, cursor_x, cursor_y, button_state, scroll_amount);
			mismatches++;
		end else begin
			want = pending_reports.pop_front();
			compare_field("cursor_valid", VALUE_W'(want.cursor_valid),
				VALUE_W'(cursor_valid));
			compare_field("cursor_x", VALUE_W'(want.cursor_x), VALUE_W'(cursor_x));
			compare_field("cursor_y", VALUE_W'(want.cursor_y), VALUE_W'(cursor_y));
			compare_field("button_event_valid", VALUE_W'(want.button_event_valid),
				VALUE_W'(button_event_valid));
			compare_field("button_down", VALUE_W'(want.button_down), VALUE_W'(button_down));
			compare_field("control_click", VALUE_W'(want.control_click),
				VALUE_W'(control_click));
			compare_field("button_state", VALUE_W'(want.button_state),
				VALUE_W'(button_state));
			compare_field("scroll_posted", VALUE_W'(want.scroll_posted),
				VALUE_W'(scroll_posted));
			compare_field("scroll_amount", want.scroll_amount, scroll_amount);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			check_report();
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic send_event(input row_t r);
		report_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= r.ev.req;
		ev_type <= r.ev.typ;
		ev_code <= r.ev.code;
		ev_value <= r.ev.value;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = assemble_report(r.ev);
		if (r.typed)
			pending_reports.push_back(r.want);
		else
			pending_reports.push_back(predicted);
		events_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_screen(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
		logic [CFG_INDEX_W-1:0] idx;
		for (int i = 0; i < 2; i++) begin
			idx = (i == 0) ? REG_SCREEN_WIDTH : REG_SCREEN_HEIGHT;
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= (idx == REG_SCREEN_WIDTH) ? w : h;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			if (idx == REG_SCREEN_WIDTH)
				screen_w = w;
			else
				screen_h = h;
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_random_reports(input int count);
		int stop_at;
		int pick;
		logic [15:0] sync_code;
		stop_at = events_sent + count;
		while (events_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 72) begin
				if ($urandom_range(3) != 0)
					send_event(plain_row(REQ_EVENT, EV_ABS, CODE_ABS_X, pick_abs_value()));
				if ($urandom_range(3) != 0)
					send_event(plain_row(REQ_EVENT, EV_ABS, CODE_ABS_Y, pick_abs_value()));
				if ($urandom_range(2) == 0)
					send_event(plain_row(REQ_EVENT, EV_KEY, CODE_BTN_LEFT, pick_key_value()));
				if ($urandom_range(2) == 0)
					send_event(plain_row(REQ_EVENT, EV_KEY, CODE_BTN_RIGHT, pick_key_value()));
				if ($urandom_range(3) == 0)
					send_event(plain_row(REQ_EVENT, EV_REL, CODE_WHEEL, pick_wheel_value()));
				sync_code = ($urandom_range(3) == 0) ? 16'($urandom) : 16'd0;
				send_event(plain_row(REQ_EVENT, EV_SYNC, sync_code, $urandom_range(1)));
			end else if (pick < 82) begin
				send_event(plain_row(REQ_TAKE_SCROLL, 16'($urandom), 16'($urandom), $urandom));
			end else if (pick < 90) begin
				send_event(plain_row(REQ_EVENT, EV_REL, CODE_WHEEL, pick_wheel_value()));
			end else if (pick < 95) begin
				send_event(plain_row(REQ_EVENT, 16'($urandom), 16'($urandom), $urandom));
			end else begin
				send_event(plain_row(REQ_EVENT, 16'($urandom_range(3)),
					16'($urandom_range(3) == 0 ? $urandom : $urandom_range(280)), $urandom));
			end
		end
	endtask

	initial begin : stimulus
		row_t dir_tab[$];
		int modes_send[4] = '{0, 74, 0, 23};
		int modes_recv[4] = '{0, 0, 74, 23};
		logic [SIZE_W-1:0] w, h;

		dir_tab.push_back(row_with_result(plain_row(REQ_TAKE_SCROLL, EV_REL, CODE_WHEEL,
			32'sh7FFF_FFFF), quiet));
		dir_tab.push_back(row_with_result(plain_row(REQ_EVENT, EV_SYNC, 16'd0, 32'sd0), quiet));
		dir_tab.push_back(row_with_result(plain_row(REQ_EVENT, EV_ABS, CODE_ABS_X,
			32'sd32767), quiet));
		dir_tab.push_back(row_with_result(plain_row(REQ_EVENT, EV_ABS, CODE_ABS_Y, -32'sd5),
			quiet));
		dir_tab.push_back(row_with_result(plain_row(REQ_EVENT, EV_SYNC, 16'hFFFF, 32'sd0),
			'{cursor_valid: 1'b1, cursor_x: 15'd640, cursor_y: 15'd1, default: '0}));
		dir_tab.push_back(plain_row(REQ_EVENT, EV_ABS, CODE_ABS_X, 32'sh8000_0000));
		dir_tab.push_back(plain_row(REQ_EVENT, EV_ABS, CODE_ABS_X, 32'sd16384));
		dir_tab.push_back(plain_row(REQ_EVENT, EV_SYNC, 16'd0, 32'sd0));
		dir_tab.push_back(row_with_result(plain_row(REQ_EVENT, EV_KEY, CODE_BTN_LEFT, 32'sd1),
			quiet));
		dir_tab.push_back(row_with_result(plain_row(REQ_EVENT, EV_SYNC, 16'd0, 32'sd0),
			'{button_event_valid: 1'b1, button_down: 1'b1, button_state: 2'd1, default: '0}));
		dir_tab.push_back(plain_row(REQ_EVENT, EV_KEY, CODE_BTN_RIGHT, -32'sd1));
		dir_tab.push_back(plain_row(REQ_EVENT, EV_KEY, CODE_BTN_LEFT, 32'sd0));
		dir_tab.push_back(plain_row(REQ_EVENT, EV_SYNC, 16'd0, 32'sd0));
		dir_tab.push_back(plain_row(REQ_EVENT, EV_KEY, CODE_BTN_RIGHT, 32'sd0));
		dir_tab.push_back(plain_row(REQ_EVENT, EV_SYNC, 16'd0, 32'sd0));
		dir_tab.push_back(plain_row(REQ_EVENT, EV_KEY, CODE_BTN_RIGHT, 32'sh8000_0000));
		dir_tab.push_back(plain_row(REQ_EVENT, EV_SYNC, 16'd0, 32'sd0));
		dir_tab.push_back(plain_row(REQ_EVENT, EV_SYNC, 16'd0, 32'sd0));
		dir_tab.push_back(plain_row(REQ_EVENT, EV_REL, CODE_WHEEL, 32'sh7FFF_FFFF));
		dir_tab.push_back(plain_row(REQ_EVENT, EV_REL, CODE_WHEEL, 32'sd5));
		dir_tab.push_back(row_with_result(plain_row(REQ_TAKE_SCROLL, 16'd0, 16'd0, 32'sd0),
			'{button_state: 2'd2, scroll_amount: SCROLL_MAX, default: '0}));
		dir_tab.push_back(plain_row(REQ_EVENT, EV_REL, CODE_WHEEL, 32'sh8000_0000));
		dir_tab.push_back(plain_row(REQ_EVENT, EV_REL, CODE_WHEEL, -32'sd1));
		dir_tab.push_back(row_with_result(plain_row(REQ_TAKE_SCROLL, 16'hFFFF, 16'hFFFF, -32'sd1),
			'{button_state: 2'd2, scroll_amount: SCROLL_MIN, default: '0}));
		dir_tab.push_back(plain_row(REQ_EVENT, 16'hFFFF, 16'hFFFF, -32'sd1));
		dir_tab.push_back(plain_row(REQ_EVENT, EV_KEY, 16'd274, 32'sd1));
		dir_tab.push_back(plain_row(REQ_EVENT, EV_REL, 16'd0, 32'sd3));
		dir_tab.push_back(plain_row(REQ_TAKE_SCROLL, 16'd0, 16'd0, 32'sd0));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_event(dir_tab[i]);
		drain();

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin w = 15'd1; h = 15'd32767; end
				1: begin w = 15'd32767; h = 15'd1; end
				2: begin w = 15'd0; h = 15'd0; end
				default: begin
					w = SIZE_W'($urandom_range(32767, 1));
					h = SIZE_W'($urandom_range(32767, 1));
				end
			endcase
			set_screen(w, h);
			send_idle_pct = modes_send[p % 4];
			recv_stall_pct = modes_recv[p % 4];
			send_random_reports(125);
			drain();
		end

		if (mismatches == 0 && pending_reports.size() == 0)
			$display("tb_pointer_event_report_assembler: done, clean");
		else
			$display("tb_pointer_event_report_assembler: done, errors");
		$finish;
	end

	initial begin
		#(2_000_000);
		$display("tb_pointer_event_report_assembler: done, errors");
		$finish;
	end

endmodule

FILE: filelist.f
src/pera_pkg.sv
src/pointer_event_report_assembler.sv
tb/tb_pointer_event_report_assembler.sv
